[src/assert_macros.svh]
// Assertion macros used by the sentence splitter parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CSFS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define CSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/csfs_pkg.sv]
// Types and character constants of the sentence field splitter.
package csfs_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] CSUM_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_FEND = 2'd1,
        KIND_SEND = 2'd2
    } t_kind;

    // Input register contents handed to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_stage;

    // One result item.
    typedef struct packed {
        t_kind       item_kind;
        logic [7:0]  field_char;
        logic [4:0]  field_number;
        logic [15:0] checksum_out;
        logic        star_seen;
        logic        too_long;
    } t_res;

    // Parser result toward the output register.
    typedef struct packed {
        logic advance;
        logic valid;
        t_res res;
    } t_res_stage;

endpackage

[src/csfs_if.sv]
// Valid/ready channel interfaces for input bytes and result items.
interface csfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface csfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  field_char;
    logic [4:0]  field_number;
    logic [15:0] checksum_out;
    logic        star_seen;
    logic        too_long;

    modport source (output valid, output item_kind, output field_char, output field_number,
                    output checksum_out, output star_seen, output too_long, input ready);
    modport sink (input valid, input item_kind, input field_char, input field_number,
                  input checksum_out, input star_seen, input too_long, output ready);
endinterface

[src/csfs_in_stage.sv]
// Input register: hold one received byte until the parser takes it.
module csfs_in_stage
    import csfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data,
    output logic        o_ready,
    input  logic        i_advance,
    output t_byte_stage o_stage
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

[src/csfs_parse.sv]
// Sentence state and per-byte decode: one byte in, at most one result out.
`include "assert_macros.svh"

module csfs_parse
    import csfs_pkg::*;
#(
    parameter int MAX_LEN    = 128,
    parameter int MAX_FIELDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_byte_stage i_stage,
    input  logic        i_out_free,
    output t_res_stage  o_stage
);

    localparam logic [7:0] LEN_LIM = 8'(MAX_LEN);
    localparam logic [5:0] FLD_LIM = 6'(MAX_FIELDS);

    logic        r_in_sentence, n_in_sentence;
    logic        r_after_star, n_after_star;
    logic        r_digits_stopped, n_digits_stopped;
    logic [4:0]  r_field_count, n_field_count;
    logic [15:0] r_checksum_acc, n_checksum_acc;
    logic [7:0]  r_byte_count, n_byte_count;
    logic        r_length_exceeded, n_length_exceeded;

    logic        advance;
    logic        res_valid;
    t_res        res;
    logic [7:0]  c;
    logic [19:0] csum_next;

    assign advance = i_stage.valid && i_out_free;
    assign c       = i_stage.data;

    // acc * 10 + digit as two shifts and adds
    assign csum_next = {1'b0, r_checksum_acc, 3'b000} + {3'b000, r_checksum_acc, 1'b0}
                     + {16'd0, 4'(c - CH_ZERO)};

    always_comb begin
        n_in_sentence     = r_in_sentence;
        n_after_star      = r_after_star;
        n_digits_stopped  = r_digits_stopped;
        n_field_count     = r_field_count;
        n_checksum_acc    = r_checksum_acc;
        n_byte_count      = r_byte_count;
        n_length_exceeded = r_length_exceeded;
        res_valid         = 1'b0;
        res               = '0;
        res.item_kind     = KIND_CHAR;

        if (advance) begin
            if (c == CH_DOLLAR) begin
                n_in_sentence     = 1'b1;
                n_after_star      = 1'b0;
                n_digits_stopped  = 1'b0;
                n_field_count     = '0;
                n_checksum_acc    = '0;
                n_byte_count      = 8'd1;
                n_length_exceeded = 1'b0;
                res_valid         = 1'b1;
                res.field_char    = c;
            end else if (r_in_sentence) begin
                if (c == CH_NL) begin
                    n_in_sentence    = 1'b0;
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_SEND;
                    res.field_number = r_field_count;
                    res.checksum_out = r_checksum_acc;
                    res.star_seen    = r_after_star;
                    res.too_long     = r_length_exceeded;
                end else if (r_byte_count >= LEN_LIM) begin
                    n_length_exceeded = 1'b1;
                end else begin
                    n_byte_count = r_byte_count + 8'd1;
                    if (r_after_star) begin
                        if (c != CH_CR && !r_digits_stopped) begin
                            if (c >= CH_ZERO && c <= CH_NINE) begin
                                n_checksum_acc = (csum_next > {4'd0, CSUM_MAX}) ?
                                                 CSUM_MAX : csum_next[15:0];
                            end else begin
                                n_digits_stopped = 1'b1;
                            end
                        end
                    end else if (c == CH_COMMA) begin
                        res_valid        = 1'b1;
                        res.item_kind    = KIND_FEND;
                        res.field_number = r_field_count;
                        if ({1'b0, r_field_count} + 6'd1 < FLD_LIM) begin
                            n_field_count = r_field_count + 5'd1;
                        end
                    end else if (c == CH_STAR) begin
                        res_valid        = 1'b1;
                        res.item_kind    = KIND_FEND;
                        res.field_number = r_field_count;
                        n_after_star     = 1'b1;
                    end else begin
                        res_valid        = 1'b1;
                        res.field_char   = c;
                        res.field_number = r_field_count;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence     <= 1'b0;
            r_after_star      <= 1'b0;
            r_digits_stopped  <= 1'b0;
            r_field_count     <= '0;
            r_checksum_acc    <= '0;
            r_byte_count      <= '0;
            r_length_exceeded <= 1'b0;
        end else begin
            r_in_sentence     <= n_in_sentence;
            r_after_star      <= n_after_star;
            r_digits_stopped  <= n_digits_stopped;
            r_field_count     <= n_field_count;
            r_checksum_acc    <= n_checksum_acc;
            r_byte_count      <= n_byte_count;
            r_length_exceeded <= n_length_exceeded;
        end
    end

    assign o_stage.advance = advance;
    assign o_stage.valid   = res_valid;
    assign o_stage.res     = res;

    `CSFS_ASSERT_ALWAYS(a_len_bound, r_byte_count <= LEN_LIM, "byte count beyond limit")
    `CSFS_ASSERT_ALWAYS(a_fld_bound, {1'b0, r_field_count} < FLD_LIM, "field count beyond limit")
    `CSFS_ASSERT_NEXT(a_dollar_starts, advance && c == CH_DOLLAR,
        r_in_sentence && r_byte_count == 8'd1 && !r_after_star, "dollar did not start clean")
    `CSFS_ASSERT_ALWAYS(a_stop_after_star, !r_digits_stopped || r_after_star,
        "digit scan stopped before star")

endmodule

[src/csfs_out_stage.sv]
// Result register: hold one result item until the consumer takes it.
module csfs_out_stage
    import csfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_stage i_stage,
    input  logic       i_ready,
    output logic       o_free,
    output logic       o_valid,
    output t_res       o_res
);

    logic r_valid;
    t_res r_res;
    logic load;

    assign o_free = !r_valid || i_ready;
    assign load   = i_stage.advance && i_stage.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_stage.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[src/comma_sentence_field_splitter_core.sv]
// A byte waits in the input register; its decoded result waits in the result register.
// Throughput: one byte per cycle; the input register and result register let bytes stream
// back to back, and a stalled result blocks new bytes only once both registers are full.
// Bytes that give no result (outside a sentence, after the star, over length) are absorbed.
// Reset (i_rst_n low, synchronous) empties both registers and clears all sentence state;
// no clearing pass follows, so an item can be taken in the first cycle after reset.
module comma_sentence_field_splitter_core
    import csfs_pkg::*;
#(
    parameter int MAX_LEN    = 128,
    parameter int MAX_FIELDS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    csfs_in_if.sink    i_rx,
    csfs_out_if.source o_res
);

    t_byte_stage byte_stage;
    t_res_stage  res_stage;
    t_res        out_res;
    logic        out_free;

    // Hold the incoming byte; advance when the result register has room.
    csfs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_data    (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .i_advance (res_stage.advance),
        .o_stage   (byte_stage)
    );

    // Decode the byte against the sentence state and update that state.
    csfs_parse #(
        .MAX_LEN    (MAX_LEN),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (byte_stage),
        .i_out_free (out_free),
        .o_stage    (res_stage)
    );

    // Register the result item for the consumer.
    csfs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (res_stage),
        .i_ready (o_res.ready),
        .o_free  (out_free),
        .o_valid (o_res.valid),
        .o_res   (out_res)
    );

    assign o_res.item_kind    = out_res.item_kind;
    assign o_res.field_char   = out_res.field_char;
    assign o_res.field_number = out_res.field_number;
    assign o_res.checksum_out = out_res.checksum_out;
    assign o_res.star_seen    = out_res.star_seen;
    assign o_res.too_long     = out_res.too_long;

endmodule
